// ===== sv/ppc_pkg.sv =====
// Shared types, constants and the divide-by-255 helper for the
// premultiplied pixel compositor. No dependencies.
`default_nettype none

package ppc_pkg;

    typedef logic [31:0] pixel_t;
    typedef logic [7:0]  chan_t;
    typedef logic [9:0]  bright_t;

    localparam chan_t  OPAQUE_ALPHA = 8'hFF;
    localparam chan_t  CHAN_MAX     = 8'd255;
    localparam pixel_t ALPHA_MASK   = 32'hFF00_0000;

    // Command codes
    localparam logic CMD_BACKGROUND = 1'b0;
    localparam logic CMD_SPRITE     = 1'b1;

    // Exact x/255 for any 16-bit x below 65535: (x + (x >> 8) + 1) >> 8
    function automatic logic [8:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return t[16:8];
    endfunction

endpackage

`default_nettype wire

// ===== sv/premultiplied_pixel_compositor.sv =====
// Premultiplied ARGB8888 compositor: brightness scale, then background or sprite over-blend.
// A transaction passes the input register, then the result register, to the output.
// One pixel per cycle while out_stall is low; the input register takes one more while a result waits.
// in_stall rises only when both registers are full and out_stall is high.
// Reset (rst_n low, asynchronous) clears both valid flags; payload registers are not reset.
// Depends on ppc_pkg, ppc_scale, ppc_blend.
`default_nettype none

module premultiplied_pixel_compositor (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire                   command,
    input  wire ppc_pkg::pixel_t  tile_pixel,
    input  wire ppc_pkg::bright_t brightness,
    input  wire                   tile_has_transparent,
    input  wire ppc_pkg::pixel_t  under_pixel,
    output logic                  out_valid,
    input  wire                   out_stall,
    output ppc_pkg::pixel_t       out_pixel,
    output logic                  write_pixel
);
    import ppc_pkg::*;

    // Input register
    logic    in_valid_reg;
    logic    cmd_reg;
    pixel_t  tile_reg;
    bright_t bright_reg;
    logic    has_tr_reg;
    pixel_t  under_reg;

    // Result register
    logic    res_valid_reg;
    pixel_t  res_pixel_reg;
    logic    res_write_reg;

    logic    in_valid_next;
    logic    res_valid_next;
    pixel_t  res_pixel_next;
    logic    res_write_next;

    logic    res_load;
    logic    in_load;

    pixel_t  scaled;
    pixel_t  blended;
    chan_t   alpha;

    // Pipeline advance
    assign res_load = !res_valid_reg || !out_stall;
    assign in_load  = !in_valid_reg || res_load;
    assign in_stall = !in_load;

    assign in_valid_next  = in_load ? in_valid : in_valid_reg;
    assign res_valid_next = res_load ? in_valid_reg : res_valid_reg;

    ppc_scale u_scale (
        .px     (tile_reg),
        .bright (bright_reg),
        .scaled (scaled)
    );

    ppc_blend u_blend (
        .src     (scaled),
        .under   (under_reg),
        .blended (blended)
    );

    assign alpha = scaled[31:24];

    // Mode selection
    always_comb
    begin
        res_pixel_next = scaled;
        res_write_next = 1'b1;
        case (cmd_reg)
            CMD_BACKGROUND:
            begin
                if (!has_tr_reg || alpha == OPAQUE_ALPHA) begin
                    res_pixel_next = scaled;
                end
                else if (alpha != 8'd0) begin
                    res_pixel_next = blended;
                end
                else begin
                    res_pixel_next = under_reg;
                end
            end
            CMD_SPRITE:
            begin
                if (alpha == OPAQUE_ALPHA) begin
                    res_pixel_next = scaled;
                end
                else if (alpha != 8'd0) begin
                    res_pixel_next = blended;
                end
                else begin
                    res_pixel_next = under_reg;
                    res_write_next = 1'b0;
                end
            end
            default:
            begin
                res_pixel_next = scaled;
                res_write_next = 1'b1;
            end
        endcase
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (in_load && in_valid) begin
            cmd_reg    <= command;
            tile_reg   <= tile_pixel;
            bright_reg <= brightness;
            has_tr_reg <= tile_has_transparent;
            under_reg  <= under_pixel;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (res_load && in_valid_reg) begin
            res_pixel_reg <= res_pixel_next;
            res_write_reg <= res_write_next;
        end
    end

    assign out_valid   = res_valid_reg;
    assign out_pixel   = res_pixel_reg;
    assign write_pixel = res_write_reg;

endmodule

`default_nettype wire

// ===== sv/ppc_scale.sv =====
// Brightness scaling of the three color channels of one pixel.
// Depends on ppc_pkg (types, constants, div255).
`default_nettype none

module ppc_scale (
    input  wire ppc_pkg::pixel_t  px,
    input  wire ppc_pkg::bright_t bright,
    output ppc_pkg::pixel_t       scaled
);
    import ppc_pkg::*;

    // Products of 255*256 and above saturate the channel
    localparam logic [17:0] SAT_LIMIT = 18'd65280;

    chan_t chan_out [3];

    genvar i;
    generate
        for (i = 0; i < 3; i++) begin : g_chan
            logic [17:0] prod;
            logic [8:0]  quot;

            assign prod = {10'd0, px[8*i +: 8]} * {8'd0, bright};
            assign quot = div255(prod[15:0]);

            // channel * brightness / 255, clamped
            always_comb
            begin
                if (prod >= SAT_LIMIT) begin
                    chan_out[i] = CHAN_MAX;
                end
                else begin
                    chan_out[i] = quot[7:0];
                end
            end
        end
    endgenerate

    // Alpha passes unchanged
    assign scaled = {px[31:24], chan_out[2], chan_out[1], chan_out[0]};

endmodule

`default_nettype wire

// ===== sv/ppc_blend.sv =====
// Premultiplied "over" blend of a source pixel onto an under pixel.
// Depends on ppc_pkg (types, constants, div255).
`default_nettype none

module ppc_blend (
    input  wire ppc_pkg::pixel_t src,
    input  wire ppc_pkg::pixel_t under,
    output ppc_pkg::pixel_t      blended
);
    import ppc_pkg::*;

    chan_t inv_alpha;
    chan_t chan_out [3];

    assign inv_alpha = CHAN_MAX - src[31:24];

    genvar i;
    generate
        for (i = 0; i < 3; i++) begin : g_chan
            logic [15:0] prod;
            logic [8:0]  quot;
            logic [9:0]  sum;

            assign prod = {8'd0, under[8*i +: 8]} * {8'd0, inv_alpha};
            assign quot = div255(prod);
            assign sum  = {2'b00, src[8*i +: 8]} + {1'b0, quot};

            // src + under*(255-a)/255, clamped
            always_comb
            begin
                if (sum > {2'b00, CHAN_MAX}) begin
                    chan_out[i] = CHAN_MAX;
                end
                else begin
                    chan_out[i] = sum[7:0];
                end
            end
        end
    endgenerate

    // Result is always opaque
    assign blended = ALPHA_MASK | {8'd0, chan_out[2], chan_out[1], chan_out[0]};

endmodule

`default_nettype wire

// ===== sv/ppc_checker.sv =====
// Port-level checks for premultiplied_pixel_compositor, bound to the top level.
// Depends on ppc_pkg and premultiplied_pixel_compositor.
`default_nettype none

module ppc_checker (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   in_valid,
    input wire                   in_stall,
    input wire                   command,
    input wire ppc_pkg::pixel_t  tile_pixel,
    input wire                   tile_has_transparent,
    input wire ppc_pkg::pixel_t  under_pixel,
    input wire                   out_valid,
    input wire                   out_stall,
    input wire ppc_pkg::pixel_t  out_pixel,
    input wire                   write_pixel
);
    import ppc_pkg::*;

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // An accepted transaction moves on to the output when the output drains
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
        else $error("result missing two cycles after accept");

    // Write flag is cleared only for a fully transparent sprite pixel
    a_write_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=>
        (write_pixel == !($past(command, 2) == CMD_SPRITE &&
                          $past(tile_pixel[31:24], 2) == 8'd0)))
        else $error("write flag wrong");

    // Zero alpha in a transparent tile or a sprite yields the under pixel
    a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && tile_pixel[31:24] == 8'd0 &&
         (command == CMD_SPRITE || tile_has_transparent)) ##1
        (!out_valid || !out_stall) |=>
        (out_pixel == $past(under_pixel, 2)))
        else $error("transparent pixel did not yield under pixel");

endmodule

bind premultiplied_pixel_compositor ppc_checker u_ppc_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .command              (command),
    .tile_pixel           (tile_pixel),
    .tile_has_transparent (tile_has_transparent),
    .under_pixel          (under_pixel),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_pixel            (out_pixel),
    .write_pixel          (write_pixel)
);

`default_nettype wire
